// File: sv/pidb_pkg.sv
// Shared types and constants for the positional insert/delete buffer.
// Used by pidb_cell, pidb_ctrl and positional_insert_delete_buffer.
package pidb_pkg;

    // Store size and derived widths
    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the item
    localparam int MODE_W   = 3;
    localparam int POS_W    = 9;
    localparam int BYTE_W   = 8;
    localparam int ST_W     = 2;
    localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Packed stream widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 24;

    // Read-out tree: groups of cells whose taps are merged and registered
    localparam int GRP      = 16;
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

    typedef enum logic [MODE_W-1:0] {
        MODE_GET    = 3'd0,
        MODE_SET    = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_REMOVE = 3'd3,
        MODE_SLICE  = 3'd4
    } t_mode;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_SET,
        SH_INS,
        SH_REM
    } t_shift;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GET,
        S_SLICE
    } t_state;

    // Command broadcast from the controller to the row of cells
    typedef struct packed {
        t_shift              op;
        logic [IDX_W-1:0]    idx;
        logic                grab;
        logic [BYTE_W-1:0]   data;
    } t_cell_cmd;

    // Per-cell load selection
    typedef struct packed {
        logic load_data;
        logic take_left;
        logic take_right;
    } t_cell_ctl;

endpackage

// File: sv/pidb_cell.sv
// One storage cell of the buffer row: a byte register fed from its
// neighbours or the request data. Depends on pidb_pkg.
module pidb_cell
    import pidb_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic              i_pick,
    input  logic [BYTE_W-1:0] i_data,
    input  logic [BYTE_W-1:0] i_left,
    input  logic [BYTE_W-1:0] i_right,
    output logic [BYTE_W-1:0] o_byte,
    output logic [BYTE_W-1:0] o_tap
);

    logic [BYTE_W-1:0] r_byte;

    // Load new byte, take from a neighbour, or hold
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_data) begin
            r_byte <= i_data;
        end else if (i_ctl.take_left) begin
            r_byte <= i_left;
        end else if (i_ctl.take_right) begin
            r_byte <= i_right;
        end
    end

    assign o_byte = r_byte;
    // Drive the read tap only when this cell is addressed
    assign o_tap  = i_pick ? r_byte : '0;

endmodule

// File: sv/pidb_ctrl.sv
// Request decoder, length counter, slice sequencer and result register.
// Depends on pidb_pkg; drives the cell row through t_cell_cmd.
module pidb_ctrl
    import pidb_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  logic [MODE_W-1:0]            i_mode,
    input  logic [POS_W-1:0]             i_pos,
    input  logic [POS_W-1:0]             i_end,
    input  logic [BYTE_W-1:0]            i_data,
    input  logic [NGRP-1:0][BYTE_W-1:0]  i_part,
    output t_cell_cmd                    o_cmd,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [BYTE_W-1:0]            o_read,
    output logic [POS_W-1:0]             o_fill,
    output logic [ST_W-1:0]              o_status
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic              r_ov, n_ov;
    logic [BYTE_W-1:0] r_read, n_read;
    logic [POS_W-1:0]  r_fill, n_fill;
    t_status           r_stat, n_stat;

    logic              out_free;
    logic              accept;
    logic              load;
    logic [CMP_W-1:0]  ex_pos, ex_end, ex_used, ex_span;
    logic [BYTE_W-1:0] merged;

    assign out_free    = !r_ov || i_res_ready;
    assign o_req_ready = (r_state == S_IDLE) && out_free;
    assign accept      = i_req_valid && o_req_ready;

    assign ex_pos  = CMP_W'(i_pos);
    assign ex_end  = CMP_W'(i_end);
    assign ex_used = CMP_W'(r_used);
    assign ex_span = ex_end - ex_pos;

    // Merge the registered group taps
    always_comb begin
        merged = '0;
        for (int g = 0; g < NGRP; g++) begin
            merged = merged | i_part[g];
        end
    end

    // Next state, cell command and result
    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_left     = r_left;
        n_pos      = r_pos;
        load       = 1'b0;
        n_read     = '0;
        n_stat     = ST_OK;
        o_cmd.op   = SH_HOLD;
        o_cmd.idx  = (r_state == S_SLICE) ? r_pos : IDX_W'(ex_pos);
        o_cmd.grab = 1'b0;
        o_cmd.data = i_data;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_mode'(i_mode))
                        MODE_GET: begin
                            if (ex_pos < ex_used) begin
                                o_cmd.grab = 1'b1;
                                n_state    = S_GET;
                            end else begin
                                load   = 1'b1;
                                n_stat = ST_BAD;
                            end
                        end
                        MODE_SET: begin
                            load = 1'b1;
                            if (ex_pos < ex_used) begin
                                o_cmd.op = SH_SET;
                            end else begin
                                n_stat = ST_BAD;
                            end
                        end
                        MODE_INSERT: begin
                            load = 1'b1;
                            if (ex_pos > ex_used) begin
                                n_stat = ST_BAD;
                            end else if (r_used == CNT_W'(CAPACITY)) begin
                                n_stat = ST_FULL;
                            end else begin
                                o_cmd.op = SH_INS;
                                n_used   = r_used + CNT_W'(1);
                            end
                        end
                        MODE_REMOVE: begin
                            load = 1'b1;
                            if (ex_pos < ex_used) begin
                                o_cmd.op = SH_REM;
                                n_used   = r_used - CNT_W'(1);
                            end else begin
                                n_stat = ST_BAD;
                            end
                        end
                        MODE_SLICE: begin
                            if (ex_pos < ex_used && ex_end <= ex_used &&
                                    ex_end > ex_pos) begin
                                // First removal now, the rest one per cycle, the last once the result register is free
                                o_cmd.op = SH_REM;
                                n_used   = r_used - CNT_W'(1);
                                if (ex_span == CMP_W'(1)) begin
                                    load = 1'b1;
                                end else begin
                                    n_left  = CNT_W'(ex_span) - CNT_W'(1);
                                    n_pos   = IDX_W'(ex_pos);
                                    n_state = S_SLICE;
                                end
                            end else begin
                                load   = 1'b1;
                                n_stat = ST_BAD;
                            end
                        end
                        default: begin
                            load   = 1'b1;
                            n_stat = ST_BAD;
                        end
                    endcase
                end
            end
            S_GET: begin
                // Deliver the byte once the result register is free
                if (out_free) begin
                    load    = 1'b1;
                    n_read  = merged;
                    n_state = S_IDLE;
                end
            end
            S_SLICE: begin
                // Advance while work remains; hold the last step for the output
                if (r_left != CNT_W'(1) || out_free) begin
                    o_cmd.op = SH_REM;
                    n_used   = r_used - CNT_W'(1);
                    n_left   = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        load    = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_fill = POS_W'(n_used);
        n_ov   = load ? 1'b1 : (r_ov && !i_res_ready);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_ov    <= n_ov;
        end
    end

    // Sequencer and result payload
    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_pos  <= n_pos;
        if (load) begin
            r_read <= n_read;
            r_fill <= n_fill;
            r_stat <= n_stat;
        end
    end

    assign o_res_valid = r_ov;
    assign o_read      = r_read;
    assign o_fill      = r_fill;
    assign o_status    = r_stat;

endmodule

// File: sv/positional_insert_delete_buffer.sv
// Top level of the positional insert/delete byte buffer: a row of cells,
// the registered read-out tree and the controller. Depends on pidb_pkg.
//
// Usage: requests enter on the s_axis channel (tuser carries the mode,
// tdata the position, slice end and data byte); every request returns
// exactly one result item on the m_axis channel (tdata carries the read
// byte and fill length, tuser the status).
// Set writes the addressed cell, and insert and remove one shift the cells
// from the position up, in the cycle the item is accepted; these and every
// rejected request give their result in the next cycle.
// Get merges the cell taps into registered groups, then the groups into
// the result register. Remove slice deletes one byte per cycle through
// the same row and loads its result with the last removal.
// One request is in flight at a time; a new item is accepted in the cycle
// the result register is emptied, so set, insert, remove one and rejected
// requests sustain one item per cycle while the receiver keeps tready high;
// a get holds the input while it waits in the S_GET state.
// When the receiver stalls, the result is held and no new item is taken.
// Reset (i_rst_n low at a clock edge) empties the buffer and the result
// register; byte cells beyond the fill length are never read.
module positional_insert_delete_buffer
    import pidb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [8:0] position, [17:9] slice_end, [25:18] data_byte, rest zero
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // [2:0] mode
    input  logic [MODE_W-1:0]   s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [7:0] read_byte, [16:8] fill_length, rest zero
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [ST_W-1:0]     m_axis_tuser
);

    t_cell_cmd                   w_cmd;
    logic [CAPACITY-1:0][BYTE_W-1:0] w_byte;
    logic [CAPACITY-1:0][BYTE_W-1:0] w_tap;
    logic [NGRP-1:0][BYTE_W-1:0] n_part;
    logic [NGRP-1:0][BYTE_W-1:0] r_part;
    logic [BYTE_W-1:0]           w_read;
    logic [POS_W-1:0]            w_fill;

    pidb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_pos       (s_axis_tdata[POS_W-1:0]),
        .i_end       (s_axis_tdata[2*POS_W-1:POS_W]),
        .i_data      (s_axis_tdata[2*POS_W+BYTE_W-1:2*POS_W]),
        .i_part      (r_part),
        .o_cmd       (w_cmd),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_read      (w_read),
        .o_fill      (w_fill),
        .o_status    (m_axis_tuser)
    );

    assign m_axis_tdata = {(M_DATA_W - BYTE_W - POS_W)'(0), w_fill, w_read};

    // Row of cells; each decodes its own move from the broadcast command
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [IDX_W-1:0] CI = IDX_W'(i);
        t_cell_ctl         ctl;
        logic              here;
        logic              above;
        logic [BYTE_W-1:0] left_b;
        logic [BYTE_W-1:0] right_b;

        assign here  = (w_cmd.idx == CI);
        assign above = (CI > w_cmd.idx);
        assign ctl.load_data  = here && (w_cmd.op == SH_SET || w_cmd.op == SH_INS);
        assign ctl.take_left  = above && (w_cmd.op == SH_INS);
        assign ctl.take_right = (here || above) && (w_cmd.op == SH_REM);

        if (i == 0) begin : g_first
            assign left_b = '0;
        end else begin : g_mid_l
            assign left_b = w_byte[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_b = w_byte[i];
        end else begin : g_mid_r
            assign right_b = w_byte[i+1];
        end

        pidb_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_pick  (here),
            .i_data  (w_cmd.data),
            .i_left  (left_b),
            .i_right (right_b),
            .o_byte  (w_byte[i]),
            .o_tap   (w_tap[i])
        );
    end

    // Merge cell taps in groups
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_part[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < CAPACITY) begin
                    n_part[g] = n_part[g] | w_tap[g * GRP + k];
                end
            end
        end
    end

    // Capture group taps when an in-range get is accepted
    always_ff @(posedge i_clk) begin
        if (w_cmd.grab) begin
            r_part <= n_part;
        end
    end

endmodule

// File: bench/pidb_checker.sv
// Scoreboard for the positional insert/delete buffer: watches both stream
// channels, predicts every result from its own copy of the byte store and
// compares it field by field. Depends on pidb_pkg.
module pidb_checker
    import pidb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    input  logic                i_s_axis_tready,
    // [8:0] position, [17:9] slice_end, [25:18] data_byte, rest zero
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // [2:0] mode
    input  logic [MODE_W-1:0]   i_s_axis_tuser,
    input  logic                i_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // [7:0] read_byte, [16:8] fill_length, rest zero
    input  logic [M_DATA_W-1:0] i_m_axis_tdata,
    // [1:0] status
    input  logic [ST_W-1:0]     i_m_axis_tuser,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_fill,
    output int                  o_checked,
    output int                  o_full_hits
);

    typedef struct packed {
        logic [BYTE_W-1:0] rd;
        logic [POS_W-1:0]  fill;
        t_status           status;
    } t_outcome;

    logic [BYTE_W-1:0] store_bytes [CAPACITY];
    int                store_len;
    t_outcome          awaited_q [$];
    int                err_count;
    int                checked_count;
    int                full_count;
    int                pending_r;
    int                fill_r;

    assign o_errors    = err_count;
    assign o_checked   = checked_count;
    assign o_full_hits = full_count;
    assign o_pending   = pending_r;
    assign o_fill      = fill_r;

    // Print one line per mismatch and count it
    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] error: %s got %0d want %0d", $time, what, got, want);
        err_count++;
    endtask

    // Apply one request to the shadow store and return the result it gives
    function automatic t_outcome apply_request(logic [MODE_W-1:0] mode, int pos,
                                               int lim, logic [BYTE_W-1:0] val);
        t_outcome r;
        int       i;
        int       span;
        r.rd     = '0;
        r.status = ST_OK;
        case (mode)
            MODE_GET: begin
                if (pos < store_len)
                    r.rd = store_bytes[pos];
                else
                    r.status = ST_BAD;
            end
            MODE_SET: begin
                if (pos < store_len)
                    store_bytes[pos] = val;
                else
                    r.status = ST_BAD;
            end
            MODE_INSERT: begin
                // bad index takes priority over full
                if (pos > store_len) begin
                    r.status = ST_BAD;
                end else if (store_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = store_len; i > pos; i--)
                        store_bytes[i] = store_bytes[i-1];
                    store_bytes[pos] = val;
                    store_len++;
                end
            end
            MODE_REMOVE: begin
                if (pos < store_len) begin
                    for (i = pos; i + 1 < store_len; i++)
                        store_bytes[i] = store_bytes[i+1];
                    store_len--;
                end else begin
                    r.status = ST_BAD;
                end
            end
            MODE_SLICE: begin
                if (pos < store_len && lim <= store_len && lim > pos) begin
                    span = lim - pos;
                    for (i = pos; i + span < store_len; i++)
                        store_bytes[i] = store_bytes[i+span];
                    store_len -= span;
                end else begin
                    r.status = ST_BAD;
                end
            end
            default: r.status = ST_BAD;
        endcase
        r.fill = POS_W'(store_len);
        return r;
    endfunction

    // Check results first, then predict for the item taken at the same edge
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            foreach (store_bytes[k])
                store_bytes[k] = '0;
            store_len     = 0;
            awaited_q.delete();
            err_count     = 0;
            checked_count = 0;
            full_count    = 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (awaited_q.size() == 0) begin
                    report_mismatch("result with nothing awaited, status",
                                    int'(i_m_axis_tuser), -1);
                end else begin
                    want = awaited_q.pop_front();
                    checked_count++;
                    if (want.status == ST_FULL)
                        full_count++;
                    if (i_m_axis_tdata[BYTE_W-1:0] !== want.rd)
                        report_mismatch("read_byte", int'(i_m_axis_tdata[BYTE_W-1:0]),
                                        int'(want.rd));
                    if (i_m_axis_tdata[BYTE_W +: POS_W] !== want.fill)
                        report_mismatch("fill_length", int'(i_m_axis_tdata[BYTE_W +: POS_W]),
                                        int'(want.fill));
                    if (i_m_axis_tuser !== want.status)
                        report_mismatch("status", int'(i_m_axis_tuser), int'(want.status));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                awaited_q.push_back(apply_request(
                    i_s_axis_tuser,
                    int'(i_s_axis_tdata[POS_W-1:0]),
                    int'(i_s_axis_tdata[POS_W +: POS_W]),
                    i_s_axis_tdata[2*POS_W +: BYTE_W]));
        end
        pending_r <= awaited_q.size();
        fill_r    <= store_len;
    end

endmodule

// File: bench/positional_insert_delete_buffer_test.sv
// Top of the insert/delete buffer bench: clock, reset, request stimulus and
// random back-pressure, with the verdict. Depends on pidb_pkg, pidb_checker
// and positional_insert_delete_buffer.
module positional_insert_delete_buffer_test;
    import pidb_pkg::*;

    // Modes the block does not define
    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    // Random phase profiles
    localparam int PH_GROW   = 0;
    localparam int PH_MIX    = 1;
    localparam int PH_SHRINK = 2;

    localparam int MAX_WAIT = 13;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [S_DATA_W-1:0] s_data  = '0;
    logic [MODE_W-1:0]   s_user  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [M_DATA_W-1:0] m_data;
    logic [ST_W-1:0]     m_user;

    int errors;
    int pending;
    int fill;
    int checked;
    int full_hits;
    int sent  = 0;
    bit quiet = 1'b0;

    positional_insert_delete_buffer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    pidb_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tuser  (m_user),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_fill          (fill),
        .o_checked       (checked),
        .o_full_hits     (full_hits)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Give up long after the slowest correct run would have finished
    initial begin
        #4_000_000;
        $display("timeout: requests still outstanding");
        $display("Mismatches found");
        $finish;
    end

    // Stall the result channel for a random number of cycles per item
    initial begin
        int stall;
        @(posedge i_clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
        end
    end

    // Idle the request channel for a random number of cycles
    task automatic hold_off();
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Present one item and hold it until the block takes it
    task automatic drive_req(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                             logic [POS_W-1:0] lim, logic [BYTE_W-1:0] val);
        s_valid <= 1'b1;
        s_user  <= mode;
        s_data  <= S_DATA_W'({val, lim, pos});
        do @(posedge i_clk); while (!s_ready);
        sent++;
    endtask

    task automatic issue(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                         logic [POS_W-1:0] lim, logic [BYTE_W-1:0] val);
        hold_off();
        drive_req(mode, pos, lim, val);
    endtask

    // Stop sending and wait until every awaited result has come back
    task automatic drain_all();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Random requests shaped around the current fill length
    task automatic run_phase(int profile, int count);
        int                w_ins, w_rem, w_get, w_set, w_slc;
        int                len, pick, start, room, span, n;
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  lim;
        logic [BYTE_W-1:0] val;
        case (profile)
            PH_GROW: begin
                w_ins = 78; w_rem = 2; w_get = 6; w_set = 6; w_slc = 1;
            end
            PH_SHRINK: begin
                w_ins = 10; w_rem = 40; w_get = 10; w_set = 10; w_slc = 20;
            end
            default: begin
                w_ins = 30; w_rem = 24; w_get = 14; w_set = 14; w_slc = 10;
            end
        endcase
        for (n = 0; n < count; n++) begin
            // switch between idling and full-rate stretches
            if (n % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            hold_off();
            len   = fill;
            pick  = $urandom_range(0, 99);
            val   = BYTE_W'($urandom_range(0, 255));
            start = (len > 0) ? $urandom_range(0, len - 1) : 0;
            pos   = POS_W'(start);
            lim   = POS_W'($urandom_range(0, 511));
            if (pick < w_ins) begin
                mode = MODE_INSERT;
                pos  = POS_W'(($urandom_range(0, 3) == 0) ? len : $urandom_range(0, len));
            end else if (pick < w_ins + w_rem) begin
                mode = MODE_REMOVE;
            end else if (pick < w_ins + w_rem + w_get) begin
                mode = MODE_GET;
            end else if (pick < w_ins + w_rem + w_get + w_set) begin
                mode = MODE_SET;
            end else if (pick < w_ins + w_rem + w_get + w_set + w_slc) begin
                // mostly short slices, now and then a long one
                mode = MODE_SLICE;
                room = len - start;
                if (room < 1)
                    span = 1;
                else if ($urandom_range(0, 15) == 0)
                    span = $urandom_range(1, room);
                else
                    span = $urandom_range(1, (room < 8) ? room : 8);
                lim = POS_W'(start + span);
            end else begin
                // noise: any mode, wild or just-out-of-range indexes
                mode = MODE_W'($urandom_range(0, 7));
                pos  = POS_W'($urandom_range(0, 511));
                if ($urandom_range(0, 1) == 1) begin
                    pos = POS_W'(len + int'(mode == MODE_INSERT));
                    lim = POS_W'(len + 1);
                end
            end
            drive_req(mode, pos, lim, val);
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty store: every access is out of range
        issue(MODE_GET,    9'd0,   9'd0,   8'h00);
        issue(MODE_REMOVE, 9'd0,   9'd0,   8'h00);
        issue(MODE_SLICE,  9'd0,   9'd1,   8'h00);
        issue(MODE_INSERT, 9'd1,   9'd0,   8'h11);
        // Build three bytes: front inserts, then an append
        issue(MODE_INSERT, 9'd0,   9'd0,   8'hFF);
        issue(MODE_INSERT, 9'd0,   9'd0,   8'h00);
        issue(MODE_INSERT, 9'd2,   9'd0,   8'hA5);
        issue(MODE_GET,    9'd0,   9'd0,   8'h00);
        issue(MODE_GET,    9'd2,   9'd0,   8'h00);
        issue(MODE_SET,    9'd1,   9'd0,   8'h5A);
        issue(MODE_GET,    9'd1,   9'd0,   8'h00);
        // Positions at and past the fill length
        issue(MODE_GET,    9'd3,   9'd0,   8'h00);
        issue(MODE_SET,    9'd3,   9'd0,   8'h77);
        issue(MODE_GET,    9'd511, 9'd0,   8'h00);
        issue(MODE_INSERT, 9'd4,   9'd0,   8'h22);
        issue(MODE_REMOVE, 9'd3,   9'd0,   8'h00);
        // Undefined modes with every field at its top value
        issue(MODE_SPARE_5, 9'd511, 9'd511, 8'hFF);
        issue(MODE_SPARE_6, 9'd511, 9'd511, 8'hFF);
        issue(MODE_SPARE_7, 9'd511, 9'd511, 8'hFF);
        // Malformed slices: empty, reversed, past the end
        issue(MODE_SLICE,  9'd1,   9'd1,   8'h00);
        issue(MODE_SLICE,  9'd2,   9'd1,   8'h00);
        issue(MODE_SLICE,  9'd0,   9'd4,   8'h00);
        // Remove the front byte, then slice the rest away
        issue(MODE_REMOVE, 9'd0,   9'd0,   8'h00);
        issue(MODE_SLICE,  9'd0,   9'd2,   8'h00);
        issue(MODE_INSERT, 9'd0,   9'd511, 8'h3C);
        drain_all();

        // Fill to capacity and beyond, churn, empty, refill, churn
        run_phase(PH_GROW, 380);
        drain_all();
        run_phase(PH_MIX, 420);
        drain_all();
        run_phase(PH_SHRINK, 150);
        drain_all();
        run_phase(PH_GROW, 250);
        drain_all();
        run_phase(PH_MIX, 350);
        drain_all();
        repeat (16) @(posedge i_clk);

        $display("covered: %0d requests sent, %0d results checked, %0d rejected as full",
                 sent, checked, full_hits);
        $display("phases filled the store to capacity, churned it and emptied it again");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
